// ===== hw/rtl/hvd_pkg.sv =====
// shared types, constants and register indexes for the three-state hmm viterbi decoder
// no dependencies
`default_nettype none

package hvd_pkg;

    localparam int NUM_STATES  = 3;
    localparam int STATE_W     = 2;
    localparam int COST_W      = 10;
    localparam int METRIC_W    = 17;
    localparam int POS_W       = 6;
    localparam int BP_W        = NUM_STATES * STATE_W;
    localparam int TRANS_W     = NUM_STATES * COST_W;
    localparam int EMIT_W      = 2 * COST_W;
    localparam int CFG_DATA_W  = TRANS_W;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_OBS_DEF = 63;

    localparam logic [METRIC_W-1:0] METRIC_MAX  = {METRIC_W{1'b1}};
    localparam logic [TRANS_W-1:0]  TRANS_RESET = TRANS_W'(26240025);
    localparam logic [EMIT_W-1:0]   EMIT_RESET  = EMIT_W'(16400);

    localparam logic [CFG_IDX_W-1:0] REG_TRANS0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EMIT0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EMIT1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EMIT2  = 3'd5;

    typedef struct packed {
        logic observation;
        logic last_obs;
    } obs_item_t;

    typedef struct packed {
        logic [STATE_W-1:0] decoded_state;
        logic [POS_W-1:0]   position;
        logic               last_state;
    } dec_item_t;

    typedef struct packed {
        logic accept;
        logic best;
        logic tb_step;
        logic emit_issue;
    } ctrl_cmd_t;

    typedef struct packed {
        logic final_in;
        logic tb_last;
        logic emit_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hvd_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module hvd_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hvd_ctrl.sv =====
// sequencing state machine: observation intake, best-state pick, traceback, result burst
// depends on hvd_pkg
`default_nettype none

module hvd_ctrl
    import hvd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       obs_valid,
    output logic            obs_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_BEST   = 2'd1;
    localparam logic [1:0] ST_TRACE  = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign obs_ready = (state_reg == ST_ACCEPT);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.accept     = obs_valid && obs_ready;
        cmd.best       = (state_reg == ST_BEST);
        cmd.tb_step    = (state_reg == ST_TRACE);
        cmd.emit_issue = (state_reg == ST_EMIT) && status.out_free;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (cmd.accept && status.final_in)
                begin
                    state_next = ST_BEST;
                end
            end
            ST_BEST:
            begin
                state_next = ST_TRACE;
            end
            ST_TRACE:
            begin
                if (status.tb_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free && status.emit_last)
                begin
                    state_next = ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCEPT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hvd_datapath.sv =====
// datapath: cost registers, add-compare-select, backpointer and path buffers, result register
// depends on hvd_pkg and hvd_ram
`default_nettype none

module hvd_datapath
    import hvd_pkg::*;
#(
    parameter int MAX_OBS = MAX_OBS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire obs_item_t             obs,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    input  wire logic                  dec_ready,
    output logic                       dec_valid,
    output dec_item_t                  result
);

    localparam int BP_DEPTH   = MAX_OBS;
    localparam int BP_AW      = (BP_DEPTH > 1) ? $clog2(BP_DEPTH) : 1;
    localparam int PATH_DEPTH = MAX_OBS + 1;
    localparam int PATH_AW    = $clog2(PATH_DEPTH);

    logic [TRANS_W-1:0]  trans_reg  [NUM_STATES];
    logic [EMIT_W-1:0]   emit_reg   [NUM_STATES];
    logic [METRIC_W-1:0] metric_reg [NUM_STATES];
    logic [METRIC_W-1:0] metric_next[NUM_STATES];

    logic [POS_W-1:0]   count_reg, count_next, count_inc;
    logic [POS_W-1:0]   n_reg, n_next;
    logic [POS_W-1:0]   x_reg, x_next;
    logic [POS_W-1:0]   e_reg, e_next;
    logic [POS_W-1:0]   opos_reg, opos_next;
    logic               olast_reg, olast_next;
    logic               ovalid_reg, ovalid_next;
    logic [STATE_W-1:0] cur_reg, cur_next;

    logic [BP_W-1:0]    bp_word;
    logic [BP_W-1:0]    bp_rdata;
    logic [POS_W-1:0]   bp_raddr;
    logic               bp_re;
    logic [STATE_W-1:0] best_state;
    logic [STATE_W-1:0] tb_state;
    logic               path_we;
    logic [POS_W-1:0]   path_waddr;
    logic [STATE_W-1:0] path_wdata;
    logic [STATE_W-1:0] path_rdata;

    // add-compare-select for each state
    always_comb
    begin
        logic [METRIC_W:0]   sum;
        logic [METRIC_W:0]   minv;
        logic [STATE_W-1:0]  arg;
        logic [COST_W-1:0]   ecost;
        logic [METRIC_W+1:0] tot;
        bp_word = '0;
        for (int s = 0; s < NUM_STATES; s++)
        begin
            minv = '0;
            arg  = '0;
            for (int p = 0; p < NUM_STATES; p++)
            begin
                sum = {1'b0, metric_reg[p]}
                    + {{(METRIC_W+1-COST_W){1'b0}}, trans_reg[s][p*COST_W +: COST_W]};
                if (p == 0 || sum < minv)
                begin
                    minv = sum;
                    arg  = STATE_W'(p);
                end
            end
            bp_word[s*STATE_W +: STATE_W] = arg;
            ecost = obs.observation ? emit_reg[s][COST_W +: COST_W] : emit_reg[s][COST_W-1:0];
            tot   = {1'b0, minv} + {{(METRIC_W+2-COST_W){1'b0}}, ecost};
            metric_next[s] = (tot > {2'b00, METRIC_MAX}) ? METRIC_MAX : tot[METRIC_W-1:0];
        end
    end

    always_comb
    begin
        best_state = '0;
        if (metric_reg[1] < metric_reg[0])
        begin
            best_state = 2'd1;
        end
        if (metric_reg[2] < metric_reg[best_state])
        begin
            best_state = 2'd2;
        end
    end

    always_comb
    begin
        case (cur_reg)
            2'd0:    tb_state = bp_rdata[1:0];
            2'd1:    tb_state = bp_rdata[3:2];
            2'd2:    tb_state = bp_rdata[5:4];
            default: tb_state = bp_rdata[1:0];
        endcase
        if (tb_state == 2'd3)
        begin
            tb_state = 2'd0;
        end
    end

    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        status.final_in  = obs.last_obs || (count_inc == POS_W'(MAX_OBS));
        status.tb_last   = (x_reg == '0);
        status.emit_last = (e_reg == n_reg);
        status.out_free  = !ovalid_reg || dec_ready;
    end

    // sequencing registers
    always_comb
    begin
        count_next  = count_reg;
        n_next      = n_reg;
        x_next      = x_reg;
        e_next      = e_reg;
        cur_next    = cur_reg;
        opos_next   = opos_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg;
        bp_re       = 1'b0;
        bp_raddr    = count_reg - 1'b1;
        path_we     = 1'b0;
        path_waddr  = count_reg;
        path_wdata  = best_state;
        if (cmd.accept)
        begin
            count_next = count_inc;
        end
        if (cmd.best)
        begin
            n_next     = count_reg;
            x_next     = count_reg - 1'b1;
            e_next     = '0;
            cur_next   = best_state;
            count_next = '0;
            bp_re      = 1'b1;
            path_we    = 1'b1;
        end
        if (cmd.tb_step)
        begin
            cur_next   = tb_state;
            path_we    = 1'b1;
            path_waddr = x_reg;
            path_wdata = tb_state;
            bp_raddr   = x_reg - 1'b1;
            bp_re      = !status.tb_last;
            x_next     = x_reg - 1'b1;
        end
        if (cmd.emit_issue)
        begin
            opos_next   = e_reg;
            olast_next  = status.emit_last;
            e_next      = e_reg + 1'b1;
            ovalid_next = 1'b1;
        end
        else if (dec_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STATES; s++)
            begin
                trans_reg[s]  <= TRANS_RESET;
                emit_reg[s]   <= EMIT_RESET;
                metric_reg[s] <= '0;
            end
            count_reg  <= '0;
            n_reg      <= '0;
            x_reg      <= '0;
            e_reg      <= '0;
            cur_reg    <= '0;
            opos_reg   <= '0;
            olast_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TRANS0: trans_reg[0] <= cfg_wdata[TRANS_W-1:0];
                    REG_TRANS1: trans_reg[1] <= cfg_wdata[TRANS_W-1:0];
                    REG_TRANS2: trans_reg[2] <= cfg_wdata[TRANS_W-1:0];
                    REG_EMIT0:  emit_reg[0]  <= cfg_wdata[EMIT_W-1:0];
                    REG_EMIT1:  emit_reg[1]  <= cfg_wdata[EMIT_W-1:0];
                    REG_EMIT2:  emit_reg[2]  <= cfg_wdata[EMIT_W-1:0];
                    default:    ;
                endcase
            end
            for (int s = 0; s < NUM_STATES; s++)
            begin
                if (cmd.accept)
                begin
                    metric_reg[s] <= metric_next[s];
                end
                else if (cmd.best)
                begin
                    metric_reg[s] <= '0;
                end
            end
            count_reg  <= count_next;
            n_reg      <= n_next;
            x_reg      <= x_next;
            e_reg      <= e_next;
            cur_reg    <= cur_next;
            opos_reg   <= opos_next;
            olast_reg  <= olast_next;
            ovalid_reg <= ovalid_next;
        end
    end

    hvd_ram #(
        .WIDTH (BP_W),
        .DEPTH (BP_DEPTH)
    ) u_bp_ram (
        .clk   (clk),
        .we    (cmd.accept),
        .waddr (count_reg[BP_AW-1:0]),
        .wdata (bp_word),
        .re    (bp_re),
        .raddr (bp_raddr[BP_AW-1:0]),
        .rdata (bp_rdata)
    );

    hvd_ram #(
        .WIDTH (STATE_W),
        .DEPTH (PATH_DEPTH)
    ) u_path_ram (
        .clk   (clk),
        .we    (path_we),
        .waddr (path_waddr[PATH_AW-1:0]),
        .wdata (path_wdata),
        .re    (cmd.emit_issue),
        .raddr (e_reg[PATH_AW-1:0]),
        .rdata (path_rdata)
    );

    assign dec_valid            = ovalid_reg;
    assign result.decoded_state = path_rdata;
    assign result.position      = opos_reg;
    assign result.last_state    = olast_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hmm_viterbi_decoder.sv =====
// Three-state hmm viterbi decoder: one observation is taken per cycle while the decoder is
// accepting, each doing a full add-compare-select update of the path metrics and writing one
// backpointer word. The final observation of a sequence of n observations (last_obs, or the
// MAX_OBS-th) is followed by a pick of the cheapest state, n steps of traceback (one backpointer
// ram read per step) and n+1 results at up to one per cycle from the path buffer, as dec_ready
// allows; the next observation is taken only after the last result has been issued.
// depends on hvd_pkg, hvd_ctrl, hvd_datapath and hvd_ram
`default_nettype none

module hmm_viterbi_decoder
    import hvd_pkg::*;
#(
    parameter int MAX_OBS = MAX_OBS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  obs_valid,
    output logic                       obs_ready,
    input  wire obs_item_t             obs,
    output logic                       dec_valid,
    input  wire logic                  dec_ready,
    output dec_item_t                  result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    hvd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .obs_valid (obs_valid),
        .obs_ready (obs_ready),
        .status    (status),
        .cmd       (cmd)
    );

    hvd_datapath #(
        .MAX_OBS (MAX_OBS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .obs       (obs),
        .cmd       (cmd),
        .status    (status),
        .dec_ready (dec_ready),
        .dec_valid (dec_valid),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== dv/hmm_viterbi_decoder_checker.sv =====
// checker for the hmm viterbi decoder: follows the config port and both channels, predicts
// the decoded state sequence of every observation sequence and compares each result
// depends on hvd_pkg
`default_nettype none

module hmm_viterbi_decoder_checker
    import hvd_pkg::*;
#(
    parameter int MAX_OBS = MAX_OBS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  obs_valid,
    input  wire logic                  obs_ready,
    input  wire obs_item_t             obs,
    input  wire logic                  dec_valid,
    input  wire logic                  dec_ready,
    input  wire dec_item_t             result,
    output int                         mismatches,
    output int                         results_due
);

    logic [TRANS_W-1:0]  trans_cost [NUM_STATES];
    logic [EMIT_W-1:0]   emit_cost [NUM_STATES];
    logic [METRIC_W-1:0] metric [NUM_STATES];
    logic [BP_W-1:0]     bp_mem [MAX_OBS];
    int unsigned         seq_len;
    dec_item_t           decoded_path [$];
    int                  errors = 0;

    task automatic advance_trellis(input obs_item_t item);
        int unsigned         cand;
        int unsigned         best_cost;
        int unsigned         nxt [NUM_STATES];
        int unsigned         n;
        int unsigned         best;
        int                  x;
        logic [STATE_W-1:0]  arg;
        logic [STATE_W-1:0]  cur;
        logic [BP_W-1:0]     bp;
        dec_item_t           trace [MAX_OBS+1];
        bp = '0;
        for (int s = 0; s < NUM_STATES; s++)
        begin
            best_cost = 0;
            arg       = '0;
            for (int p = 0; p < NUM_STATES; p++)
            begin
                cand = metric[p] + trans_cost[s][COST_W*p +: COST_W];
                if (p == 0 || cand < best_cost)
                begin
                    best_cost = cand;
                    arg       = STATE_W'(p);
                end
            end
            bp[STATE_W*s +: STATE_W] = arg;
            cand = best_cost + (item.observation ? emit_cost[s][COST_W +: COST_W]
                                                 : emit_cost[s][0 +: COST_W]);
            nxt[s] = (cand > METRIC_MAX) ? METRIC_MAX : cand;
        end
        for (int s = 0; s < NUM_STATES; s++)
            metric[s] = METRIC_W'(nxt[s]);
        if (seq_len >= MAX_OBS)
            seq_len = MAX_OBS - 1;
        bp_mem[seq_len] = bp;
        seq_len++;
        if (!item.last_obs && seq_len < MAX_OBS)
            return;

        n    = seq_len;
        best = 0;
        for (int s = 1; s < NUM_STATES; s++)
            if (metric[s] < metric[best])
                best = s;
        cur = STATE_W'(best);
        for (x = n; x >= 0; x--)
        begin
            trace[x].decoded_state = cur;
            trace[x].position      = POS_W'(x);
            trace[x].last_state    = (x == n);
            if (x > 0)
            begin
                cur = bp_mem[x-1][STATE_W*cur +: STATE_W];
                if (cur > STATE_W'(NUM_STATES - 1))
                    cur = '0;
            end
        end
        for (x = 0; x <= n; x++)
            decoded_path = {decoded_path, trace[x]};
        for (int s = 0; s < NUM_STATES; s++)
            metric[s] = '0;
        seq_len = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dec_item_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STATES; s++)
            begin
                trans_cost[s] = TRANS_RESET;
                emit_cost[s]  = EMIT_RESET;
                metric[s]     = '0;
            end
            seq_len = 0;
            decoded_path.delete();
            results_due <= 0;
            mismatches  <= errors;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TRANS0: trans_cost[0] = cfg_wdata;
                    REG_TRANS1: trans_cost[1] = cfg_wdata;
                    REG_TRANS2: trans_cost[2] = cfg_wdata;
                    REG_EMIT0:  emit_cost[0]  = cfg_wdata[EMIT_W-1:0];
                    REG_EMIT1:  emit_cost[1]  = cfg_wdata[EMIT_W-1:0];
                    REG_EMIT2:  emit_cost[2]  = cfg_wdata[EMIT_W-1:0];
                    default:    ;
                endcase
            end
            if (obs_valid && obs_ready)
                advance_trellis(obs);
            if (dec_valid && dec_ready)
            begin
                if (decoded_path.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, actual %0d/%0d/%0b", $time,
                             result.decoded_state, result.position, result.last_state);
                end
                else
                begin
                    want = decoded_path.pop_front();
                    if (result !== want)
                    begin
                        errors++;
                        $display("%0t: mismatch, expected %0d/%0d/%0b, actual %0d/%0d/%0b",
                                 $time, want.decoded_state, want.position, want.last_state,
                                 result.decoded_state, result.position, result.last_state);
                    end
                end
            end
            results_due <= decoded_path.size();
            mismatches  <= errors;
        end
    end

endmodule

`default_nettype wire

// ===== dv/hmm_viterbi_decoder_test.sv =====
// testbench top for the hmm viterbi decoder: clock, reset, cost register loads, bursty
// observation sequences and a stalling result side, with the verdict at the end
// depends on hvd_pkg, hmm_viterbi_decoder and hmm_viterbi_decoder_checker
`default_nettype none

module hmm_viterbi_decoder_test
    import hvd_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int PHASE_ITEMS = 14;
    localparam int DRAIN_LIMIT = 20000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  obs_valid;
    logic                  obs_ready;
    obs_item_t             obs;
    logic                  dec_valid;
    logic                  dec_ready = 1'b0;
    dec_item_t             result;
    int                    mismatches;
    int                    results_due;

    int                    burst_left = 0;
    bit                    steady = 1'b0;
    int                    phase_items;
    logic [9:0]            stall_tick = '0;

    always #2 clk = ~clk;

    hmm_viterbi_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .obs_valid (obs_valid),
        .obs_ready (obs_ready),
        .obs       (obs),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .result    (result)
    );

    hmm_viterbi_decoder_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .obs_valid   (obs_valid),
        .obs_ready   (obs_ready),
        .obs         (obs),
        .dec_valid   (dec_valid),
        .dec_ready   (dec_ready),
        .result      (result),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    // result side stall pattern, changing character as stall_tick[8:7] steps
    always @(posedge clk)
    begin
        stall_tick++;
        case (stall_tick[8:7])
            2'd0:    dec_ready <= 1'b1;
            2'd1:    dec_ready <= 1'($urandom_range(0, 1));
            2'd2:    dec_ready <= (stall_tick[1:0] == 2'd0);
            default: dec_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    initial
    begin
        #400000;
        $display("** hmm_viterbi_decoder: FAILED **");
        $finish;
    end

    function automatic logic [TRANS_W-1:0] pack_costs(input int unsigned c0, c1, c2);
        return {COST_W'(c2), COST_W'(c1), COST_W'(c0)};
    endfunction

    function automatic logic [TRANS_W-1:0] rand_costs(input int unsigned hi);
        return pack_costs($urandom_range(0, hi), $urandom_range(0, hi), $urandom_range(0, hi));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic load_costs(input logic [TRANS_W-1:0] t0, t1, t2,
                              input logic [EMIT_W-1:0] e0, e1, e2);
        write_reg(REG_TRANS0, t0);
        write_reg(REG_TRANS1, t1);
        write_reg(REG_TRANS2, t2);
        write_reg(REG_EMIT0, CFG_DATA_W'(e0));
        write_reg(REG_EMIT1, CFG_DATA_W'(e1));
        write_reg(REG_EMIT2, CFG_DATA_W'(e2));
        // writes to unused indexes must leave the costs alone
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic send_observation(input logic sym, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0)
            begin
                obs_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        obs_valid <= 1'b1;
        obs       <= '{observation: sym, last_obs: fin};
        @(posedge clk);
        while (!obs_ready)
            @(posedge clk);
        burst_left--;
        phase_items++;
    endtask

    task automatic send_sequence(input int len);
        for (int i = 0; i < len; i++)
            send_observation(1'($urandom_range(0, 1)), i == len - 1);
    endtask

    // let all decoded sequences come out, then give the block time to settle
    task automatic settle();
        int guard;
        obs_valid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (results_due != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (2 * MAX_OBS_DEF + 8) @(posedge clk);
    endtask

    initial
    begin
        logic [TRANS_W-1:0] t [NUM_STATES];
        logic [EMIT_W-1:0]  e [NUM_STATES];
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        obs_valid <= 1'b0;
        obs       <= '0;
        rst_n     <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // reset costs: all ties, single observation sequences
        send_observation(1'b0, 1'b1);
        send_observation(1'b1, 1'b1);
        settle();

        // sticky states with clear emission preferences
        load_costs(pack_costs(2, 30, 30), pack_costs(30, 2, 30), pack_costs(30, 30, 2),
                   EMIT_W'({10'd40, 10'd1}), EMIT_W'({10'd1, 10'd40}),
                   EMIT_W'({10'd10, 10'd10}));
        steady = 1'b1;
        send_observation(1'b0, 1'b0);
        send_observation(1'b0, 1'b0);
        send_observation(1'b0, 1'b0);
        send_observation(1'b1, 1'b0);
        send_observation(1'b1, 1'b0);
        send_observation(1'b1, 1'b0);
        send_observation(1'b1, 1'b0);
        send_observation(1'b0, 1'b0);
        send_observation(1'b1, 1'b0);
        send_observation(1'b0, 1'b1);
        steady = 1'b0;
        send_observation(1'b1, 1'b0);
        send_observation(1'b1, 1'b0);
        send_observation(1'b0, 1'b1);
        send_observation(1'b1, 1'b1);
        settle();

        for (int ph = 0; ph < 8; ph++)
        begin
            for (int s = 0; s < NUM_STATES; s++)
            begin
                case (ph)
                    0:
                    begin
                        t[s] = '0;
                        e[s] = '0;
                    end
                    1:
                    begin
                        t[s] = '1;
                        e[s] = '1;
                    end
                    3, 6:
                    begin
                        t[s] = rand_costs(15);
                        e[s] = EMIT_W'(rand_costs(15));
                    end
                    4:
                    begin
                        t[s] = '0;
                        e[s] = EMIT_W'(rand_costs(1023));
                    end
                    7:
                    begin
                        t[s] = TRANS_RESET;
                        e[s] = EMIT_RESET;
                    end
                    default:
                    begin
                        t[s] = rand_costs(1023);
                        e[s] = EMIT_W'(rand_costs(1023));
                    end
                endcase
            end
            load_costs(t[0], t[1], t[2], e[0], e[1], e[2]);
            steady      = (ph % 4 == 3);
            phase_items = 0;
            // long run past a full store, forced to end at the last entry
            if (ph == 2 || ph == 6)
                send_sequence(MAX_OBS_DEF + $urandom_range(0, 4));
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                send_sequence(($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 10));
            settle();
        end

        if (mismatches == 0 && results_due == 0)
            $display("** hmm_viterbi_decoder: PASSED **");
        else
            $display("** hmm_viterbi_decoder: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
